// ----- design/gdr_pkg.sv -----
package gdr_pkg;

	localparam int MAP_BITS   = 5;
	localparam int MAP_SIZE   = 1 << MAP_BITS;
	localparam int FRAC_BITS  = 16;
	localparam int ANGLE_BITS = 12;
	localparam int POS_W      = MAP_BITS + FRAC_BITS;
	localparam int CELL_W     = 8;
	localparam int ADDR_W     = 2 * MAP_BITS;
	localparam int QTR_BITS   = ANGLE_BITS - 2;
	localparam int QTR        = 1 << QTR_BITS;
	localparam int MAG_W      = FRAC_BITS + 1;
	localparam int DIV_STEPS  = 2 * FRAC_BITS + 1;
	localparam int DELTA_W    = 2 * FRAC_BITS + 2;
	localparam int SD_W       = DELTA_W + 7;
	localparam int CAP_BITS   = 38;
	localparam int WALK_MAX   = 2 * MAP_SIZE + 2;
	localparam int CNT_W      = $clog2(WALK_MAX + 1);
	localparam int DIST_W     = 24;
	localparam int TEX_W      = 16;
	localparam int CODE_W     = 7;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CAST  = 1'b1;

	typedef logic [MAG_W-1:0] sin_tab_t [0:QTR];

	typedef struct packed {
		logic                     req_type;
		logic [MAP_BITS-1:0]      cell_x;
		logic [MAP_BITS-1:0]      cell_y;
		logic signed [CELL_W-1:0] cell_value;
		logic [POS_W-1:0]         start_x;
		logic [POS_W-1:0]         start_y;
		logic [ANGLE_BITS-1:0]    ray_angle;
	} req_t;

	typedef struct packed {
		logic [DIST_W-1:0] hit_distance;
		logic              hit_side;
		logic [TEX_W-1:0]  texture_offset;
		logic [CODE_W-1:0] wall_code;
		logic              out_of_bounds;
	} res_t;

	typedef struct packed {
		logic clr;
		logic wr_cell;
		logic load;
		logic rom_rd_x;
		logic rom_rd_y;
		logic lat_x;
		logic lat_y;
		logic div_start;
		logic mul;
		logic side_init;
		logic walk_step;
		logic finish;
		logic tex;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic start_oob;
		logic div_done;
		logic leave;
		logic wall;
		logic limit;
	} stat_t;

	// quarter-wave sine by Taylor series in Q30, rounded to the fraction width
	function automatic sin_tab_t build_sin_tab();
		sin_tab_t    tab;
		logic [63:0] x, x2, sum, term, r;
		for (int q = 0; q <= QTR; q++) begin
			x = (64'(q) * HALF_PI_Q30) >> QTR_BITS;
			x2 = (x * x) >> 30;
			sum = x;
			term = x;
			for (int k = 1; k <= 6; k++) begin
				term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if ((k % 2) == 1) sum = (sum > term) ? sum - term : 64'd0;
				else sum = sum + term;
			end
			r = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
			if (r > (64'd1 << FRAC_BITS)) r = 64'd1 << FRAC_BITS;
			tab[q] = r[MAG_W-1:0];
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// ----- design/gdr_recip.sv -----
module gdr_recip (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [gdr_pkg::MAG_W-1:0]       divisor,
	output logic                            done,
	output logic [gdr_pkg::DELTA_W-1:0]     quotient
);

	localparam int SCNT_W = $clog2(gdr_pkg::DIV_STEPS + 1);

	logic [SCNT_W-1:0]              cnt_q;
	logic [gdr_pkg::MAG_W-1:0]      rem_q;
	logic [gdr_pkg::DIV_STEPS-1:0]  quo_q;
	logic [gdr_pkg::MAG_W:0]        trial;
	logic                           fits;

	// shift in the next dividend bit: 2^(2F) has only its top bit set
	assign trial = {rem_q, (cnt_q == SCNT_W'(gdr_pkg::DIV_STEPS))};
	assign fits  = trial >= {1'b0, divisor};

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= SCNT_W'(gdr_pkg::DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? gdr_pkg::MAG_W'(trial - {1'b0, divisor}) : trial[gdr_pkg::MAG_W-1:0];
			quo_q <= {quo_q[gdr_pkg::DIV_STEPS-2:0], fits};
		end
	end

	assign done = (cnt_q == '0);
	// zero component saturates to a step larger than any real one
	assign quotient = (divisor == '0) ? (gdr_pkg::DELTA_W'(1) << (gdr_pkg::DELTA_W - 1))
	                                  : gdr_pkg::DELTA_W'(quo_q);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !done)
		else $error("divider reports done right after start");

endmodule

// ----- design/gdr_datapath.sv -----
module gdr_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  gdr_pkg::req_t   req,
	input  gdr_pkg::cmd_t   cmd,
	output gdr_pkg::stat_t  st,
	output gdr_pkg::res_t   res
);

	localparam int F  = gdr_pkg::FRAC_BITS;
	localparam int MW = gdr_pkg::MAG_W;
	localparam int DW = gdr_pkg::DELTA_W;
	localparam int SW = gdr_pkg::SD_W;
	localparam int MB = gdr_pkg::MAP_BITS;
	localparam int AB = gdr_pkg::ANGLE_BITS;
	localparam int CB = gdr_pkg::CAP_BITS;
	localparam logic [SW-1:0] PERP_CAP = SW'(1) << CB;
	localparam logic [CB:0] DIST_MAX = (CB + 1)'({gdr_pkg::DIST_W{1'b1}});

	// request registers
	logic [gdr_pkg::POS_W-1:0] sx_q, sy_q;
	logic [AB-1:0]             ang_q;
	logic                      startoob_q;

	// map memory
	logic [gdr_pkg::CELL_W-1:0] mem [0:(1 << gdr_pkg::ADDR_W)-1];
	logic [gdr_pkg::CELL_W-1:0] rdata_q;
	logic [gdr_pkg::ADDR_W-1:0] clr_addr_q, waddr, raddr;
	logic [gdr_pkg::CELL_W-1:0] wdata;
	logic                       we;

	// direction
	logic [AB-1:0]   ang_sel;
	logic [AB-2:0]   rom_idx;
	logic [MW-1:0]   rom_q;
	logic [1:0]      quad_q;
	logic [MW-1:0]   magx_q, magy_q;
	logic            negx_q, negy_q;

	// step lengths and side distances
	logic [DW-1:0]   dlx, dly;
	logic            donex, doney;
	logic [MW-1:0]   fx, fy;
	logic [MW+DW-F-1:0] phx_s, phy_s;
	logic [MW+F-1:0] plx_s, ply_s;
	logic [SW-1:0]   sdx_q, sdy_q, perp_q;
	logic [MB:0]     mx_q, my_q, nmx, nmy;
	logic            stepx, side_q, leave_q;
	logic [gdr_pkg::CNT_W-1:0] cnt_q;
	logic [gdr_pkg::CODE_W-1:0] code_q;
	logic            oob_q, wall;

	// texture stage
	logic [CB:0]     pc;
	logic [MW-1:0]   mag;
	logic [CB-F+MW-1:0] mh_s;
	logic [F+MW-1:0] ml_s;
	logic [gdr_pkg::DIST_W-1:0] dist_s;
	logic            dneg_s;
	logic [F-1:0]    st16_s, prodf, prodc, tex;

	// latch cast request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q  <= req.start_x;
			sy_q  <= req.start_y;
			ang_q <= req.ray_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startoob_q <= 1'b0;
		end else if (cmd.load) begin
			startoob_q <= ((MB + 1)'(req.start_x[gdr_pkg::POS_W-1:F]) >= (MB + 1)'(gdr_pkg::MAP_SIZE))
			           || ((MB + 1)'(req.start_y[gdr_pkg::POS_W-1:F]) >= (MB + 1)'(gdr_pkg::MAP_SIZE));
		end
	end

	// sweep the map clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign we    = cmd.clr | cmd.wr_cell;
	assign waddr = cmd.clr ? clr_addr_q : {req.cell_x, req.cell_y};
	assign wdata = cmd.clr ? '0 : req.cell_value;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// fold the angle onto the quarter-wave table
	assign ang_sel = cmd.rom_rd_y ? ang_q : ang_q + AB'(gdr_pkg::QTR);
	assign rom_idx = ang_sel[AB-2] ? (AB-1)'(gdr_pkg::QTR) - (AB-1)'(ang_sel[AB-3:0])
	                               : (AB-1)'(ang_sel[AB-3:0]);

	always_ff @(posedge clk) begin
		if (cmd.rom_rd_x | cmd.rom_rd_y) begin
			rom_q  <= gdr_pkg::SIN_TAB[rom_idx];
			quad_q <= ang_sel[AB-1:AB-2];
		end
		if (cmd.lat_x) begin
			magx_q <= rom_q;
			negx_q <= quad_q[1] && (rom_q != '0);
		end
		if (cmd.lat_y) begin
			magy_q <= rom_q;
			negy_q <= quad_q[1] && (rom_q != '0);
		end
	end

	gdr_recip u_recip_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (magx_q),
		.done     (donex),
		.quotient (dlx)
	);

	gdr_recip u_recip_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (magy_q),
		.done     (doney),
		.quotient (dly)
	);

	// initial side distances: fraction to the first boundary times step length
	assign fx = negx_q ? MW'(sx_q[F-1:0]) : (MW'(1) << F) - MW'(sx_q[F-1:0]);
	assign fy = negy_q ? MW'(sy_q[F-1:0]) : (MW'(1) << F) - MW'(sy_q[F-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			phx_s <= (MW+DW-F)'(fx) * (MW+DW-F)'(dlx[DW-1:F]);
			plx_s <= (MW+F)'(fx) * (MW+F)'(dlx[F-1:0]);
			phy_s <= (MW+DW-F)'(fy) * (MW+DW-F)'(dly[DW-1:F]);
			ply_s <= (MW+F)'(fy) * (MW+F)'(dly[F-1:0]);
		end
	end

	// next cell in either direction
	assign stepx = sdx_q < sdy_q;
	assign nmx   = negx_q ? mx_q - 1'b1 : mx_q + 1'b1;
	assign nmy   = negy_q ? my_q - 1'b1 : my_q + 1'b1;
	assign raddr = stepx ? {nmx[MB-1:0], my_q[MB-1:0]} : {mx_q[MB-1:0], nmy[MB-1:0]};
	assign wall  = !rdata_q[gdr_pkg::CELL_W-1] && (rdata_q != '0);

	// set up the walk, then advance it one boundary per walk step
	always_ff @(posedge clk) begin
		if (cmd.side_init) begin
			sdx_q <= SW'(phx_s) + SW'(plx_s >> F);
			sdy_q <= SW'(phy_s) + SW'(ply_s >> F);
			mx_q  <= {1'b0, sx_q[gdr_pkg::POS_W-1:F]};
			my_q  <= {1'b0, sy_q[gdr_pkg::POS_W-1:F]};
		end else if (cmd.walk_step) begin
			if (stepx) begin
				perp_q  <= sdx_q;
				sdx_q   <= sdx_q + SW'(dlx);
				mx_q    <= nmx;
				side_q  <= 1'b0;
				leave_q <= nmx[MB];
			end else begin
				perp_q  <= sdy_q;
				sdy_q   <= sdy_q + SW'(dly);
				my_q    <= nmy;
				side_q  <= 1'b1;
				leave_q <= nmy[MB];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.side_init) begin
			cnt_q <= '0;
		end else if (cmd.walk_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// hold the hit code once the walk ends
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			code_q <= (!leave_q && wall) ? rdata_q[gdr_pkg::CODE_W-1:0] : '0;
			oob_q  <= !(!leave_q && wall);
		end
	end

	// perpendicular distance and wall-face product
	assign pc  = (perp_q > PERP_CAP) ? PERP_CAP[CB:0] : perp_q[CB:0];
	assign mag = side_q ? magx_q : magy_q;

	always_ff @(posedge clk) begin
		if (cmd.tex) begin
			mh_s   <= (CB-F+MW)'(pc[CB:F]) * (CB-F+MW)'(mag);
			ml_s   <= (F+MW)'(pc[F-1:0]) * (F+MW)'(mag);
			dist_s <= (pc > DIST_MAX) ? DIST_MAX[gdr_pkg::DIST_W-1:0] : pc[gdr_pkg::DIST_W-1:0];
			dneg_s <= side_q ? negx_q : negy_q;
			st16_s <= side_q ? sx_q[F-1:0] : sy_q[F-1:0];
		end
	end

	// low bits of the hit point, rounding away from the start when heading down
	assign prodf = mh_s[F-1:0] + ml_s[2*F-1:F];
	assign prodc = mh_s[F-1:0] + F'((ml_s + (F+MW)'({F{1'b1}})) >> F);
	assign tex   = dneg_s ? st16_s - prodc : st16_s + prodf;

	assign res.hit_distance   = startoob_q ? '0 : dist_s;
	assign res.hit_side       = startoob_q ? 1'b0 : side_q;
	assign res.texture_offset = startoob_q ? '0 : gdr_pkg::TEX_W'(tex);
	assign res.wall_code      = startoob_q ? '0 : code_q;
	assign res.out_of_bounds  = startoob_q | oob_q;

	assign st.clr_done  = (clr_addr_q == '1);
	assign st.start_oob = startoob_q;
	assign st.div_done  = donex & doney;
	assign st.leave     = leave_q;
	assign st.wall      = wall;
	assign st.limit     = (cnt_q == gdr_pkg::CNT_W'(gdr_pkg::WALK_MAX));

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> (cnt_q < gdr_pkg::CNT_W'(gdr_pkg::WALK_MAX)))
		else $error("walk stepped past its limit");

endmodule

// ----- design/gdr_ctrl.sv -----
module gdr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            req_type,
	input  gdr_pkg::stat_t  st,
	output gdr_pkg::cmd_t   cmd,
	output logic            busy,
	output logic            res_valid
);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_SIN0 = 4'd2;
	localparam logic [3:0] ST_SIN1 = 4'd3;
	localparam logic [3:0] ST_SIN2 = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_DIVW = 4'd6;
	localparam logic [3:0] ST_MUL  = 4'd7;
	localparam logic [3:0] ST_SIDE = 4'd8;
	localparam logic [3:0] ST_STEP = 4'd9;
	localparam logic [3:0] ST_TEST = 4'd10;
	localparam logic [3:0] ST_TEX  = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	logic [3:0] state_q, state_d;

	// sequence one request through the datapath
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (st.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					if (req_type == gdr_pkg::REQ_CAST) begin
						cmd.load = 1'b1;
						state_d  = ST_SIN0;
					end else begin
						cmd.wr_cell = 1'b1;
					end
				end
			end
			ST_SIN0: begin
				if (st.start_oob) begin
					state_d = ST_OUT;
				end else begin
					cmd.rom_rd_x = 1'b1;
					state_d      = ST_SIN1;
				end
			end
			ST_SIN1: begin
				cmd.rom_rd_y = 1'b1;
				cmd.lat_x    = 1'b1;
				state_d      = ST_SIN2;
			end
			ST_SIN2: begin
				cmd.lat_y = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (st.div_done) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SIDE;
			end
			ST_SIDE: begin
				cmd.side_init = 1'b1;
				state_d       = ST_STEP;
			end
			ST_STEP: begin
				cmd.walk_step = 1'b1;
				state_d       = ST_TEST;
			end
			ST_TEST: begin
				if (st.leave || st.wall || st.limit) begin
					cmd.finish = 1'b1;
					state_d    = ST_TEX;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_TEX: begin
				cmd.tex = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_OUT);

	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid)
		else $error("result beat repeated");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVW && !st.div_done) |=> (state_q == ST_DIVW))
		else $error("left divide wait before quotients were ready");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_cell |=> (state_q == ST_IDLE))
		else $error("cell write left idle");

endmodule

// ----- design/grid_dda_raycaster.sv -----
// Channel   Handshake            Payload                 Notes
// request   start & !busy        req  (gdr_pkg::req_t)   write cell or cast ray
// result    res_valid, one cycle res  (gdr_pkg::res_t)   one beat per cast, none per write
//
// A cell write is done in idle; busy stays low.
// A cast runs from acceptance to its result beat through the direction, divide and walk
// states, and the next request is taken in the cycle after that beat: two 33-step
// reciprocal dividers run side by side, then the walk spends a step state and a test
// state on each cell, reading the map memory's registered read port.
// After reset the map memory is swept to zero with busy high.
// The receiver cannot stall; each result beat is valid for exactly one cycle.
module grid_dda_raycaster (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  gdr_pkg::req_t  req,
	output logic           res_valid,
	output gdr_pkg::res_t  res
);

	gdr_pkg::cmd_t  cmd;
	gdr_pkg::stat_t st;

	gdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req.req_type),
		.st        (st),
		.cmd       (cmd),
		.busy      (busy),
		.res_valid (res_valid)
	);

	gdr_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.res    (res)
	);

endmodule
